// ===== rtl/crtsm_pkg.sv =====
package crtsm_pkg;

   // Geometry of one tile and of one pixel.
   localparam int SCALE = 4;
   localparam int CHAN_W = 8;
   localparam int CHANNELS = 3;
   localparam int PIX_W = CHAN_W * CHANNELS;
   localparam int ROW_W = 2;
   localparam int PHASE_W = 2;

   localparam logic [ROW_W-1:0] ROW_FIRST = ROW_W'(0);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SCALE - 1);

   // Column phases of the phosphor mask.
   localparam logic [PHASE_W-1:0] PHASE_0 = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_1 = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_2 = 2'd2;

   // Phosphor colour selectors.
   localparam logic [1:0] PHOS_R = 2'd0;
   localparam logic [1:0] PHOS_G = 2'd1;
   localparam logic [1:0] PHOS_B = 2'd2;

   // Tile row codes.
   localparam logic [ROW_W-1:0] ROW_UPPER = 2'd0;
   localparam logic [ROW_W-1:0] ROW_BRIGHT = 2'd1;
   localparam logic [ROW_W-1:0] ROW_LOWER = 2'd2;

   typedef logic [PIX_W-1:0] pixel_type;
   typedef logic [CHAN_W-1:0] chan_type;

   // One tile to be drawn: neighborhood, column phase and line-end mark.
   typedef struct packed {
      pixel_type left;
      pixel_type centre;
      pixel_type right;
      logic [PHASE_W-1:0] phase;
      logic last;
   } job_type;

   // Up to two tiles caused by one input transaction, in output order.
   typedef struct packed {
      job_type job0;
      job_type job1;
      logic valid0;
      logic valid1;
   } item_type;

   // One tile row request for the row shader.
   typedef struct packed {
      job_type job;
      logic [ROW_W-1:0] row;
   } row_req_type;

   // One finished tile row.
   typedef struct packed {
      logic [ROW_W-1:0] row;
      pixel_type px0;
      pixel_type px1;
      pixel_type px2;
      pixel_type px3;
      logic tile_done;
      logic line_done;
   } row_out_type;

   // Horizontal blur per channel: (left + 6*centre + right) >> 3.
   function automatic pixel_type blur(pixel_type l, pixel_type c, pixel_type r);
      logic [CHAN_W+2:0] sum;
      pixel_type res;
      res = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         sum = (CHAN_W+3)'(l[ch*CHAN_W +: CHAN_W])
             + (CHAN_W+3)'(c[ch*CHAN_W +: CHAN_W]) * (CHAN_W+3)'(6)
             + (CHAN_W+3)'(r[ch*CHAN_W +: CHAN_W]);
         res[ch*CHAN_W +: CHAN_W] = sum[CHAN_W+2:3];
      end
      return res;
   endfunction

   // Dim each channel by 27/32.
   function automatic pixel_type dim(pixel_type v);
      chan_type c;
      pixel_type res;
      res = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         c = v[ch*CHAN_W +: CHAN_W];
         res[ch*CHAN_W +: CHAN_W] = c - (c >> 3) - (c >> 5);
      end
      return res;
   endfunction

   // Scanline weight of a tile row: 7/8, 1, 15/16 and 11/16.
   function automatic pixel_type scale_row(pixel_type v, logic [ROW_W-1:0] row);
      chan_type c;
      chan_type s;
      pixel_type res;
      res = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         c = v[ch*CHAN_W +: CHAN_W];
         case (row)
            ROW_UPPER: s = c - (c >> 3);
            ROW_BRIGHT: s = c;
            ROW_LOWER: s = c - (c >> 4);
            default: s = c - (c >> 2) - (c >> 4);
         endcase
         res[ch*CHAN_W +: CHAN_W] = s;
      end
      return res;
   endfunction

   // Phosphor colour of a tile column: (phase + column) mod 3.
   function automatic logic [1:0] phos_pick(logic [PHASE_W-1:0] phase, logic [1:0] col);
      logic [2:0] sum;
      logic [1:0] res;
      sum = 3'(phase) + 3'(col);
      case (sum)
         3'd0, 3'd3: res = PHOS_R;
         3'd1, 3'd4: res = PHOS_G;
         default: res = PHOS_B;
      endcase
      return res;
   endfunction

endpackage

// ===== rtl/crtsm_line_tracker.sv =====
module crtsm_line_tracker (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  crtsm_pkg::pixel_type pixel,
   input  logic                line_end,
   output crtsm_pkg::item_type item,
   output logic                has_work
);

   crtsm_pkg::pixel_type left_ff, left_in;
   crtsm_pkg::pixel_type centre_ff, centre_in;
   logic pending_ff, pending_in;
   logic [crtsm_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [crtsm_pkg::PHASE_W-1:0] phase_next;

   // Column phase of the pixel that follows the held one.
   always_comb begin
      case (phase_ff)
         crtsm_pkg::PHASE_0: phase_next = crtsm_pkg::PHASE_1;
         crtsm_pkg::PHASE_1: phase_next = crtsm_pkg::PHASE_2;
         default: phase_next = crtsm_pkg::PHASE_0;
      endcase
   end

   // The held pixel's tile goes out now that its right neighbor is known;
   // a line-end pixel's tile goes out at once.
   always_comb begin
      item.job0.left   = left_ff;
      item.job0.centre = centre_ff;
      item.job0.right  = pixel;
      item.job0.phase  = phase_ff;
      item.job0.last   = 1'b0;
      item.valid0      = pending_ff;

      item.job1.left   = pending_ff ? centre_ff : pixel;
      item.job1.centre = pixel;
      item.job1.right  = pixel;
      item.job1.phase  = pending_ff ? phase_next : crtsm_pkg::PHASE_0;
      item.job1.last   = 1'b1;
      item.valid1      = line_end;

      has_work = pending_ff | line_end;
   end

   // Neighborhood state update for each accepted transaction.
   always_comb begin
      left_in    = left_ff;
      centre_in  = centre_ff;
      pending_in = pending_ff;
      phase_in   = phase_ff;
      if (accept) begin
         left_in    = item.job1.left;
         centre_in  = pixel;
         pending_in = ~line_end;
         phase_in   = line_end ? crtsm_pkg::PHASE_0 : item.job1.phase;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff    <= '0;
         centre_ff  <= '0;
         pending_ff <= 1'b0;
         phase_ff   <= crtsm_pkg::PHASE_0;
      end else begin
         left_ff    <= left_in;
         centre_ff  <= centre_in;
         pending_ff <= pending_in;
         phase_ff   <= phase_in;
      end
   end

endmodule

// ===== rtl/crtsm_tile_seq.sv =====
module crtsm_tile_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  crtsm_pkg::item_type     item,
   input  logic                    out_free,
   output logic                    busy,
   output logic                    issue,
   output logic                    done,
   output crtsm_pkg::row_req_type  req
);

   crtsm_pkg::item_type item_ff, item_in;
   logic busy_ff, busy_in;
   logic sel_ff, sel_in;
   logic [crtsm_pkg::ROW_W-1:0] row_ff, row_in;
   logic at_end;

   // A row goes out whenever the result register can take it.
   always_comb begin
      issue  = busy_ff & out_free;
      at_end = (row_ff == crtsm_pkg::ROW_LAST) & (sel_ff | ~item_ff.valid1);
      done   = issue & at_end;
      busy   = busy_ff;
      req.job = sel_ff ? item_ff.job1 : item_ff.job0;
      req.row = row_ff;
   end

   // Walk the rows of the first tile, then those of the second if present.
   always_comb begin
      item_in = item_ff;
      busy_in = busy_ff;
      sel_in  = sel_ff;
      row_in  = row_ff;
      if (load) begin
         item_in = item;
         busy_in = 1'b1;
         sel_in  = ~item.valid0;
         row_in  = crtsm_pkg::ROW_FIRST;
      end else if (issue) begin
         if (row_ff == crtsm_pkg::ROW_LAST) begin
            if (at_end) begin
               busy_in = 1'b0;
            end else begin
               sel_in = 1'b1;
               row_in = crtsm_pkg::ROW_FIRST;
            end
         end else begin
            row_in = row_ff + crtsm_pkg::ROW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (reset) begin
         busy_ff <= 1'b0;
         sel_ff  <= 1'b0;
         row_ff  <= crtsm_pkg::ROW_FIRST;
      end else begin
         busy_ff <= busy_in;
         sel_ff  <= sel_in;
         row_ff  <= row_in;
      end
   end

endmodule

// ===== rtl/crtsm_row_shader.sv =====
module crtsm_row_shader (
   input  crtsm_pkg::row_req_type req,
   input  logic                   crt_mode,
   output crtsm_pkg::row_out_type result
);

   crtsm_pkg::pixel_type colour;
   crtsm_pkg::pixel_type dimmed;
   crtsm_pkg::pixel_type phos_r, phos_g, phos_b;
   crtsm_pkg::pixel_type px [crtsm_pkg::SCALE];

   localparam int CW = crtsm_pkg::CHAN_W;

   // Blur, dim, and keep one channel bright for each phosphor colour.
   always_comb begin
      colour = crtsm_pkg::blur(req.job.left, req.job.centre, req.job.right);
      dimmed = crtsm_pkg::dim(colour);
      phos_r = {colour[3*CW-1:2*CW], dimmed[2*CW-1:0]};
      phos_g = {dimmed[3*CW-1:2*CW], colour[2*CW-1:CW], dimmed[CW-1:0]};
      phos_b = {dimmed[3*CW-1:CW], colour[CW-1:0]};
   end

   // Lay the mask over the four columns and weight the row in CRT mode, else repeat the centre.
   always_comb begin
      crtsm_pkg::pixel_type v;
      for (int col = 0; col < crtsm_pkg::SCALE; col++) begin
         case (crtsm_pkg::phos_pick(req.job.phase, 2'(col)))
            crtsm_pkg::PHOS_R: v = phos_r;
            crtsm_pkg::PHOS_G: v = phos_g;
            default: v = phos_b;
         endcase
         px[col] = crt_mode ? crtsm_pkg::scale_row(v, req.row) : req.job.centre;
      end
   end

   always_comb begin
      result.row       = req.row;
      result.px0       = px[0];
      result.px1       = px[1];
      result.px2       = px[2];
      result.px3       = px[3];
      result.tile_done = (req.row == crtsm_pkg::ROW_LAST);
      result.line_done = (req.row == crtsm_pkg::ROW_LAST) & req.job.last;
   end

endmodule

// ===== rtl/crt_scanline_mask_upscaler_core.sv =====
// 4x upscaler with optional CRT look (blur, phosphor mask, scanlines).
//
// Source pixels enter on the req_ channel, left to right, with
// req_line_end on the last pixel of each line. Every pixel becomes a 4x4
// tile that leaves on the rsp_ channel as four transactions, tile rows 0
// to 3, each carrying four output pixels. A pixel's tile needs its right
// neighbor, so it leaves after the next pixel of the line arrives; the
// tile of a line-end pixel follows right behind it.
// The csr_ channel writes crt_mode (0 nearest, 1 CRT); write it only while
// no tile rows are outstanding. csr_ready is always high.
// A tile's first row passes the sequencer's item register, then the result
// register, after the req_ transaction that releases it. Throughput: one
// tile row per cycle unless stalled; a line end that also releases the held
// pixel gives two tiles. The row sequencer and the one result register set
// this rate. A new pixel is taken during the last row of the previous one.
// When rsp_ready is low the result register holds its row and the sequencer
// stalls; req_ready drops once the current pixel's rows are not all out.
// Reset clears the held pixel, the line position and crt_mode, and empties
// the result register.
module crt_scanline_mask_upscaler_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [23:0]          req_pixel_rgb,
   input  logic                 req_line_end,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_tile_row,
   output logic [23:0]          rsp_sub_pixel0,
   output logic [23:0]          rsp_sub_pixel1,
   output logic [23:0]          rsp_sub_pixel2,
   output logic [23:0]          rsp_sub_pixel3,
   output logic                 rsp_tile_done,
   output logic                 rsp_line_done,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_crt_mode
);

   crtsm_pkg::item_type item;
   crtsm_pkg::row_req_type row_req;
   crtsm_pkg::row_out_type row_out;
   crtsm_pkg::row_out_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic mode_ff, mode_in;
   logic has_work, busy, issue, done, out_free, req_accept;

   // Handshakes.
   always_comb begin
      out_free   = ~rsp_valid_ff | rsp_ready;
      req_ready  = ~busy | done;
      req_accept = req_valid & req_ready;
      csr_ready  = 1'b1;
   end

   crtsm_line_tracker u_tracker (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .pixel    (req_pixel_rgb),
      .line_end (req_line_end),
      .item     (item),
      .has_work (has_work)
   );

   crtsm_tile_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .load     (req_accept & has_work),
      .item     (item),
      .out_free (out_free),
      .busy     (busy),
      .issue    (issue),
      .done     (done),
      .req      (row_req)
   );

   crtsm_row_shader u_shader (
      .req      (row_req),
      .crt_mode (mode_ff),
      .result   (row_out)
   );

   // Mode register and result register.
   always_comb begin
      mode_in      = (csr_valid & csr_ready) ? csr_crt_mode : mode_ff;
      rsp_in       = issue ? row_out : rsp_ff;
      rsp_valid_in = issue | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      rsp_valid      = rsp_valid_ff;
      rsp_tile_row   = rsp_ff.row;
      rsp_sub_pixel0 = rsp_ff.px0;
      rsp_sub_pixel1 = rsp_ff.px1;
      rsp_sub_pixel2 = rsp_ff.px2;
      rsp_sub_pixel3 = rsp_ff.px3;
      rsp_tile_done  = rsp_ff.tile_done;
      rsp_line_done  = rsp_ff.line_done;
   end

endmodule

// ===== rtl/crtsm_checker.sv =====
module crtsm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_tile_row,
   input logic [23:0] rsp_sub_pixel0,
   input logic        rsp_tile_done,
   input logic        rsp_line_done
);

   // The result channel is empty right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The tile-done mark belongs to the last tile row, and line-done implies it.
   a_done_marks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tile_done == (rsp_tile_row == 2'd3))
                    && (!rsp_line_done || rsp_tile_done))
      else $error("tile or line done mark on the wrong row");

   // Rows of a tile follow each other without a gap once one is taken.
   a_row_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_tile_row != 2'd3 |=>
         rsp_valid && rsp_tile_row == $past(rsp_tile_row) + 2'd1)
      else $error("tile rows out of order");

   // A stalled result row holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_tile_row) && $stable(rsp_sub_pixel0))
      else $error("result changed while stalled");

endmodule

bind crt_scanline_mask_upscaler_core crtsm_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_tile_row   (rsp_tile_row),
   .rsp_sub_pixel0 (rsp_sub_pixel0),
   .rsp_tile_done  (rsp_tile_done),
   .rsp_line_done  (rsp_line_done)
);

// ===== tb/crt_scanline_mask_upscaler_core_tb.sv =====
`timescale 1ns / 1ps

module crt_scanline_mask_upscaler_core_tb;

   localparam int RESET_CYCLES = 8;
   localparam int SETTLE_CYCLES = 8;
   localparam int FINAL_CYCLES = 16;
   localparam int HOLD_CYCLES = 80;
   localparam int CYCLE_LIMIT = 200000;
   localparam int N_PHASES = 6;
   localparam int ITEMS_PER_PHASE = 18;
   localparam int PRESSURE_PHASE = 2;
   localparam int PAUSE_PHASE = 3;
   localparam int REPORT_LIMIT = 10;

   // One directed stimulus row. When flat is set, every sub-pixel of the
   // pixel's tile must equal the pixel itself.
   typedef struct packed {
      logic crt_mode;
      crtsm_pkg::pixel_type pixel;
      logic line_end;
      logic flat;
   } stim_row_type;

   localparam int N_DIRECTED = 24;
   localparam stim_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      // Nearest mode: one-pixel lines straight after reset, then a
      // three-pixel line, then a pixel left held across a mode change.
      '{1'b0, 24'hFFFFFF, 1'b1, 1'b1},
      '{1'b0, 24'h000000, 1'b1, 1'b1},
      '{1'b0, 24'h123456, 1'b1, 1'b1},
      '{1'b0, 24'hA5C3E1, 1'b0, 1'b0},
      '{1'b0, 24'h5A3C1E, 1'b0, 1'b0},
      '{1'b0, 24'hFF00FF, 1'b1, 1'b0},
      '{1'b0, 24'h00FF00, 1'b0, 1'b0},
      // CRT mode: the held pixel's tile now uses the new mode.
      '{1'b1, 24'h0000FF, 1'b1, 1'b0},
      '{1'b1, 24'hFFFFFF, 1'b1, 1'b0},
      '{1'b1, 24'h000000, 1'b1, 1'b1},
      // Five-pixel line: the column phase wraps past a multiple of three.
      '{1'b1, 24'hFF0000, 1'b0, 1'b0},
      '{1'b1, 24'h00FF00, 1'b0, 1'b0},
      '{1'b1, 24'h0000FF, 1'b0, 1'b0},
      '{1'b1, 24'hFFFFFF, 1'b0, 1'b0},
      '{1'b1, 24'h808080, 1'b1, 1'b0},
      // Four-pixel and two-pixel lines.
      '{1'b1, 24'h010203, 1'b0, 1'b0},
      '{1'b1, 24'hFEFDFC, 1'b0, 1'b0},
      '{1'b1, 24'h7F7F7F, 1'b0, 1'b0},
      '{1'b1, 24'h800000, 1'b1, 1'b0},
      '{1'b1, 24'hFFFFFF, 1'b0, 1'b0},
      '{1'b1, 24'h000000, 1'b1, 1'b0},
      // Back to nearest mode.
      '{1'b0, 24'hABCDEF, 1'b1, 1'b1},
      '{1'b0, 24'h00000F, 1'b0, 1'b0},
      '{1'b0, 24'hF00000, 1'b1, 1'b0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   crtsm_pkg::pixel_type req_pixel_rgb = '0;
   logic req_line_end = 1'b0;
   logic flat_tile_mark = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [crtsm_pkg::ROW_W-1:0] rsp_tile_row;
   crtsm_pkg::pixel_type rsp_sub_pixel0;
   crtsm_pkg::pixel_type rsp_sub_pixel1;
   crtsm_pkg::pixel_type rsp_sub_pixel2;
   crtsm_pkg::pixel_type rsp_sub_pixel3;
   logic rsp_tile_done;
   logic rsp_line_done;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_crt_mode = 1'b0;

   // Traffic shaping, set per phase by the stimulus process.
   logic gap_en = 1'b0;
   logic rsp_stall_en = 1'b0;
   logic hold_req = 1'b0;
   int unsigned burst_left = 1;
   int unsigned cycle_count = 0;
   int unsigned fail_count = 0;

   // Predictor state.
   logic crt_mode_now = 1'b0;
   crtsm_pkg::pixel_type held_left = '0;
   crtsm_pkg::pixel_type held_centre = '0;
   logic held_pending = 1'b0;
   logic line_starting = 1'b1;
   logic [crtsm_pkg::PHASE_W-1:0] held_phase = crtsm_pkg::PHASE_0;
   crtsm_pkg::row_out_type tile_row_q [$];

   crt_scanline_mask_upscaler_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_rgb  (req_pixel_rgb),
      .req_line_end   (req_line_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_tile_row   (rsp_tile_row),
      .rsp_sub_pixel0 (rsp_sub_pixel0),
      .rsp_sub_pixel1 (rsp_sub_pixel1),
      .rsp_sub_pixel2 (rsp_sub_pixel2),
      .rsp_sub_pixel3 (rsp_sub_pixel3),
      .rsp_tile_done  (rsp_tile_done),
      .rsp_line_done  (rsp_line_done),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_crt_mode   (csr_crt_mode)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Expected tile rows of one tile, appended in output order.
   function automatic void queue_tile(crtsm_pkg::pixel_type l, crtsm_pkg::pixel_type c,
                                      crtsm_pkg::pixel_type r,
                                      logic [crtsm_pkg::PHASE_W-1:0] ph, logic last,
                                      logic flat);
      crtsm_pkg::pixel_type smooth;
      crtsm_pkg::pixel_type dimmed;
      crtsm_pkg::pixel_type phos [3];
      crtsm_pkg::pixel_type cols [crtsm_pkg::SCALE];
      logic [crtsm_pkg::CHAN_W+2:0] acc;
      crtsm_pkg::chan_type s;
      crtsm_pkg::row_out_type tr;
      smooth = '0;
      dimmed = '0;
      for (int ch = 0; ch < crtsm_pkg::CHANNELS; ch++) begin
         acc = (crtsm_pkg::CHAN_W+3)'(l[ch*crtsm_pkg::CHAN_W +: crtsm_pkg::CHAN_W])
             + (crtsm_pkg::CHAN_W+3)'(c[ch*crtsm_pkg::CHAN_W +: crtsm_pkg::CHAN_W])
               * (crtsm_pkg::CHAN_W+3)'(6)
             + (crtsm_pkg::CHAN_W+3)'(r[ch*crtsm_pkg::CHAN_W +: crtsm_pkg::CHAN_W]);
         s = acc[crtsm_pkg::CHAN_W+2:3];
         smooth[ch*crtsm_pkg::CHAN_W +: crtsm_pkg::CHAN_W] = s;
         dimmed[ch*crtsm_pkg::CHAN_W +: crtsm_pkg::CHAN_W] = s - (s >> 3) - (s >> 5);
      end
      // Each phosphor keeps one channel at full blur brightness.
      if (crt_mode_now) begin
         phos[0] = {smooth[23:16], dimmed[15:0]};
         phos[1] = {dimmed[23:16], smooth[15:8], dimmed[7:0]};
         phos[2] = {dimmed[23:8], smooth[7:0]};
      end else begin
         phos = '{c, c, c};
      end
      for (int row = 0; row < crtsm_pkg::SCALE; row++) begin
         for (int col = 0; col < crtsm_pkg::SCALE; col++) begin
            cols[col] = phos[(int'(ph) + col) % 3];
            if (crt_mode_now) begin
               for (int ch = 0; ch < crtsm_pkg::CHANNELS; ch++) begin
                  s = cols[col][ch*crtsm_pkg::CHAN_W +: crtsm_pkg::CHAN_W];
                  case (crtsm_pkg::ROW_W'(row))
                     crtsm_pkg::ROW_UPPER: s = s - (s >> 3);
                     crtsm_pkg::ROW_LOWER: s = s - (s >> 4);
                     crtsm_pkg::ROW_LAST: s = s - (s >> 2) - (s >> 4);
                     default: s = s;
                  endcase
                  cols[col][ch*crtsm_pkg::CHAN_W +: crtsm_pkg::CHAN_W] = s;
               end
            end
            if (flat) begin
               cols[col] = c;
            end
         end
         tr.row = crtsm_pkg::ROW_W'(row);
         tr.px0 = cols[0];
         tr.px1 = cols[1];
         tr.px2 = cols[2];
         tr.px3 = cols[3];
         tr.tile_done = (row == crtsm_pkg::SCALE - 1);
         tr.line_done = last && (row == crtsm_pkg::SCALE - 1);
         tile_row_q.push_back(tr);
      end
   endfunction

   // Advance the line state by one source pixel and queue the tiles it releases.
   function automatic void upscale_pixel(crtsm_pkg::pixel_type px, logic last, logic flat);
      logic was_pending;
      was_pending = held_pending;
      if (was_pending) begin
         queue_tile(held_left, held_centre, px, held_phase, 1'b0, flat);
         held_left = held_centre;
         held_phase = (held_phase == crtsm_pkg::PHASE_2) ? crtsm_pkg::PHASE_0
                                                         : held_phase + crtsm_pkg::PHASE_1;
      end
      if (line_starting || !was_pending) begin
         held_left = px;
         held_phase = crtsm_pkg::PHASE_0;
      end
      held_centre = px;
      if (last) begin
         queue_tile(held_left, px, px, held_phase, 1'b1, flat);
         held_pending = 1'b0;
         line_starting = 1'b1;
         held_phase = crtsm_pkg::PHASE_0;
      end else begin
         held_pending = 1'b1;
         line_starting = 1'b0;
      end
   endfunction

   // Compare one output transaction with the oldest expected tile row.
   function automatic void check_tile_row();
      crtsm_pkg::row_out_type want;
      if (tile_row_q.size() == 0) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: unexpected tile row %0d: %h %h %h %h tile_done %b line_done %b",
                     $realtime, rsp_tile_row, rsp_sub_pixel0, rsp_sub_pixel1,
                     rsp_sub_pixel2, rsp_sub_pixel3, rsp_tile_done, rsp_line_done);
         end
         return;
      end
      want = tile_row_q.pop_front();
      if (rsp_tile_row !== want.row || rsp_sub_pixel0 !== want.px0
          || rsp_sub_pixel1 !== want.px1 || rsp_sub_pixel2 !== want.px2
          || rsp_sub_pixel3 !== want.px3 || rsp_tile_done !== want.tile_done
          || rsp_line_done !== want.line_done) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: tile row mismatch, expected row %0d %h %h %h %h %b %b",
                     $realtime, want.row, want.px0, want.px1, want.px2, want.px3,
                     want.tile_done, want.line_done);
            $display("%0t:                      got row %0d %h %h %h %h %b %b",
                     $realtime, rsp_tile_row, rsp_sub_pixel0, rsp_sub_pixel1,
                     rsp_sub_pixel2, rsp_sub_pixel3, rsp_tile_done, rsp_line_done);
         end
      end
   endfunction

   // Watch all three channels; a csr and a req transaction never share an edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            crt_mode_now = csr_crt_mode;
         end
         if (req_valid && req_ready) begin
            upscale_pixel(req_pixel_rgb, req_line_end, flat_tile_mark);
         end
         if (rsp_valid && rsp_ready) begin
            check_tile_row();
         end
      end
   end

   // Receiver: always ready, a random ready pattern, or a long hold-off on request.
   initial begin : rsp_stall_gen
      logic [31:0] ready_pattern;
      int unsigned pattern_pos;
      int unsigned hold_left;
      ready_pattern = '1;
      pattern_pos = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
         end
         if (pattern_pos == 0) begin
            case ($urandom_range(0, 3))
               0: ready_pattern = '1;
               1: ready_pattern = $urandom();
               default: ready_pattern = $urandom() | $urandom();
            endcase
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!rsp_stall_en) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ready_pattern[pattern_pos];
         end
         pattern_pos = (pattern_pos + 1) % 32;
      end
   end

   // Run timeout.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("crt_scanline_mask_upscaler_core_tb: FAIL");
         $finish;
      end
   end

   // Offer one pixel and hold it until the transaction completes.
   task automatic send_pixel(input crtsm_pkg::pixel_type px, input logic last,
                             input logic flat);
      req_valid <= 1'b1;
      req_pixel_rgb <= px;
      req_line_end <= last;
      flat_tile_mark <= flat;
      do @(posedge clock); while (!req_ready);
      // Bursts of random length separated by random gaps.
      if (gap_en) begin
         if (burst_left > 1) begin
            burst_left--;
         end else begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 8);
         end
      end
   endtask

   // Stop offering pixels and wait until every expected row is out.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (tile_row_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_crt_mode(input logic mode);
      csr_valid <= 1'b1;
      csr_crt_mode <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic crtsm_pkg::pixel_type random_pixel();
      crtsm_pkg::pixel_type px;
      px = '0;
      case ($urandom_range(0, 5))
         0: px = '0;
         1: px = '1;
         2: begin
            for (int ch = 0; ch < crtsm_pkg::CHANNELS; ch++) begin
               case ($urandom_range(0, 2))
                  0: px[ch*crtsm_pkg::CHAN_W +: crtsm_pkg::CHAN_W] = '0;
                  1: px[ch*crtsm_pkg::CHAN_W +: crtsm_pkg::CHAN_W] = '1;
                  default: px[ch*crtsm_pkg::CHAN_W +: crtsm_pkg::CHAN_W] =
                     crtsm_pkg::CHAN_W'($urandom());
               endcase
            end
         end
         default: px = crtsm_pkg::PIX_W'($urandom());
      endcase
      return px;
   endfunction

   function automatic int unsigned random_line_len();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         return 1;
      end else if (pick < 8) begin
         return $urandom_range(2, 5);
      end
      return $urandom_range(6, 12);
   endfunction

   // Stimulus: directed table, then random lines in several phases.
   initial begin : stimulus
      int unsigned items_left;
      int unsigned line_len;
      logic mode_sel;
      logic mode_driven;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_crt_mode(1'b0);
      mode_driven = 1'b0;

      rsp_stall_en = 1'b1;
      for (int i = 0; i < N_DIRECTED; i++) begin
         if (DIRECTED_ROWS[i].crt_mode != mode_driven) begin
            drain_results();
            write_crt_mode(DIRECTED_ROWS[i].crt_mode);
            mode_driven = DIRECTED_ROWS[i].crt_mode;
         end
         send_pixel(DIRECTED_ROWS[i].pixel, DIRECTED_ROWS[i].line_end,
                    DIRECTED_ROWS[i].flat);
      end
      drain_results();

      for (int ph = 0; ph < N_PHASES; ph++) begin
         case (ph)
            0: begin
               gap_en = 1'b0;
               rsp_stall_en = 1'b0;
               mode_sel = 1'b1;
            end
            1: begin
               gap_en = 1'b1;
               rsp_stall_en = 1'b1;
               mode_sel = 1'b0;
            end
            PRESSURE_PHASE: begin
               gap_en = 1'b0;
               rsp_stall_en = 1'b0;
               mode_sel = 1'b1;
            end
            PAUSE_PHASE: begin
               gap_en = 1'b1;
               rsp_stall_en = 1'b1;
               mode_sel = 1'($urandom_range(0, 1));
            end
            4: begin
               gap_en = 1'b1;
               rsp_stall_en = 1'b0;
               mode_sel = 1'b1;
            end
            default: begin
               gap_en = 1'b0;
               rsp_stall_en = 1'b1;
               mode_sel = 1'b0;
            end
         endcase
         write_crt_mode(mode_sel);
         // The receiver holds off while the sender keeps pushing pixels.
         if (ph == PRESSURE_PHASE) begin
            hold_req = 1'b1;
         end
         items_left = ITEMS_PER_PHASE;
         while (items_left != 0) begin
            line_len = random_line_len();
            for (int k = 0; k < line_len && items_left != 0; k++) begin
               send_pixel(random_pixel(), k == line_len - 1, 1'b0);
               items_left--;
               if (ph == PAUSE_PHASE && items_left == ITEMS_PER_PHASE / 2) begin
                  drain_results();
               end
            end
         end
         drain_results();
      end

      repeat (FINAL_CYCLES) @(posedge clock);
      if (tile_row_q.size() != 0) begin
         fail_count++;
         $display("%0t: %0d expected tile rows never arrived", $realtime,
                  tile_row_q.size());
      end
      if (fail_count == 0) begin
         $display("crt_scanline_mask_upscaler_core_tb: PASS");
      end else begin
         $display("crt_scanline_mask_upscaler_core_tb: FAIL");
      end
      $finish;
   end

endmodule
